// ----- hw/rtl/i2s_fifo_register_block_assert.svh -----
// assertion macros for the i2s register block
`ifndef I2S_FIFO_REGISTER_BLOCK_ASSERT_SVH
`define I2S_FIFO_REGISTER_BLOCK_ASSERT_SVH

// condition holds at every clock edge outside reset
`define IFRB_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define IFRB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/i2sfrb_pkg.sv -----
package i2sfrb_pkg;

  // item kinds
  typedef enum logic [2:0] {
    MODE_BUS_READ   = 3'd0,
    MODE_BUS_WRITE  = 3'd1,
    MODE_DMA_POP    = 3'd2,
    MODE_DMA_PUSH   = 3'd3,
    MODE_DRAIN_TICK = 3'd4,
    MODE_CLOCK_CTRL = 3'd5
  } mode_t;

  // register byte offsets
  localparam logic [7:0] OFF_CTRL     = 8'h00;
  localparam logic [7:0] OFF_INT      = 8'h04;
  localparam logic [7:0] OFF_BCLK     = 8'h10;
  localparam logic [7:0] OFF_FIFO_CFG0 = 8'h80;
  localparam logic [7:0] OFF_FIFO_CFG1 = 8'h84;
  localparam logic [7:0] OFF_TX_DATA  = 8'h88;
  localparam logic [7:0] OFF_RX_DATA  = 8'h8C;
  localparam logic [7:0] OFF_PIN      = 8'hFC;

  // register widths
  localparam int CtrlW = 21;
  localparam int IntW  = 27;
  localparam int BclkW = 28;
  localparam int ThrW  = 28;
  localparam int PinW  = 8;

  // write masks and reset values
  localparam logic [IntW-1:0]  INT_CTRL_MASK  = 27'h7000700;
  localparam logic [IntW-1:0]  INT_CTRL_RESET = 27'h7000700;
  localparam logic [BclkW-1:0] BCLK_MASK      = 28'hFFF0FFF;
  localparam logic [BclkW-1:0] BCLK_RESET     = 28'h0010001;
  localparam logic [ThrW-1:0]  THR_MASK       = 28'hF0F0000;
  localparam logic [31:0]      FREE_MASK      = 32'h0000001F;

  // bit positions
  localparam int CTRL_TX_EN     = 2;
  localparam int FCF_DMA_TX_EN  = 0;
  localparam int FCF_TX_OVER    = 4;
  localparam int FCF_RX_UNDER   = 7;
  localparam int WR_TX_FLUSH    = 2;
  localparam int WR_RX_CLEAR    = 3;
  localparam int INT_TX_MASK    = 8;
  localparam int INT_ERR_MASK   = 10;
  localparam int INT_TX_EN      = 24;
  localparam int INT_ERR_EN     = 26;
  localparam int THR_TX_LO      = 16;

  // clock flags: bit 0 clock on, bit 1 module clock on, bit 2 reset asserted
  localparam logic [2:0] CLK_FLAGS_RESET  = 3'b011;
  localparam logic [2:0] CLK_FLAGS_ACTIVE = 3'b011;
  localparam int         CLK_RESET_BIT    = 2;

  localparam logic [3:0] DMA_MAX_WIDTH = 4'd4;

endpackage

// ----- hw/rtl/i2s_fifo_register_block.sv -----
// channel  | valid     | stall     | payload
// ---------+-----------+-----------+---------------------------------------------
// input    | in_valid  | in_stall  | mode offset write_data dma_width clock bits
// output   | out_valid | out_stall | read_data irq dma_write_ready
//          |           |           | dma_read_ready drain_pending
//
// one item per cycle while in_stall is low; its result is registered at the accepting edge
// state update and result are computed in one pass from the state registers
// into the result register
// rst (synchronous) returns registers, fill count and clock flags to reset values
// in_stall rises only while the result register is full and out_stall is high
`include "i2s_fifo_register_block_assert.svh"

module i2s_fifo_register_block
  import i2sfrb_pkg::*;
#(
  parameter int FIFO_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  mode,
  input  logic [7:0]  offset,
  input  logic [31:0] write_data,
  input  logic [3:0]  dma_width,
  input  logic        clock_on,
  input  logic        module_clock_on,
  input  logic        reset_on,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] read_data,
  output logic        irq,
  output logic        dma_write_ready,
  output logic        dma_read_ready,
  output logic        drain_pending
);

  localparam int FillW = $clog2(FIFO_DEPTH + 1);
  localparam int CmpW  = (FillW > 4) ? FillW : 4;
  localparam logic [FillW-1:0] Depth = FillW'(FIFO_DEPTH);

  // state registers
  logic [CtrlW-1:0] control_word, control_word_next;
  logic [IntW-1:0]  interrupt_control, interrupt_control_next;
  logic [BclkW-1:0] bit_clock_word, bit_clock_word_next;
  logic [31:0]      fifo_control_flags, fifo_control_flags_next;
  logic [ThrW-1:0]  fifo_thresholds, fifo_thresholds_next;
  logic [PinW-1:0]  pin_config, pin_config_next;
  logic [FillW-1:0] tx_fill, tx_fill_next;
  logic             drain_waiting, drain_waiting_next;
  logic [2:0]       clock_flags, clock_flags_next;

  logic        accept;
  logic        active, active_next;
  logic [FillW-1:0] free_cur, free_next;
  logic        cause_tx_cur, cause_err_cur, cause_tx_next, cause_err_next;
  logic [31:0] rd_next;
  logic        irq_next;
  logic        wr_ready_next;
  logic [3:0]  sticky;

  assign accept   = in_valid && !in_stall;
  assign in_stall = out_valid && out_stall;

  // live causes of the current state, for status reads
  assign active        = (clock_flags == CLK_FLAGS_ACTIVE);
  assign free_cur      = Depth - tx_fill;
  assign cause_tx_cur  = CmpW'(free_cur) >
                         CmpW'(fifo_thresholds[THR_TX_LO +: 4]);
  assign cause_err_cur = |fifo_control_flags[7:4];

  // next state for one item
  always_comb begin
    control_word_next       = control_word;
    interrupt_control_next  = interrupt_control;
    bit_clock_word_next     = bit_clock_word;
    fifo_control_flags_next = fifo_control_flags;
    fifo_thresholds_next    = fifo_thresholds;
    pin_config_next         = pin_config;
    tx_fill_next            = tx_fill;
    drain_waiting_next      = drain_waiting;
    clock_flags_next        = clock_flags;
    sticky                  = fifo_control_flags[7:4];
    rd_next                 = '0;

    unique case (mode)
      MODE_BUS_READ: begin
        unique case (offset)
          OFF_CTRL:      rd_next = 32'(control_word);
          OFF_INT:       rd_next = 32'(interrupt_control & INT_CTRL_MASK)
                                   | {29'b0, cause_err_cur, 1'b0, cause_tx_cur};
          OFF_BCLK:      rd_next = 32'(bit_clock_word);
          OFF_FIFO_CFG0: rd_next = fifo_control_flags;
          OFF_FIFO_CFG1: rd_next = 32'(free_cur) & FREE_MASK;
          OFF_RX_DATA:   fifo_control_flags_next[FCF_RX_UNDER] = 1'b1;
          OFF_PIN:       rd_next = 32'(pin_config);
          default:       rd_next = '0;
        endcase
      end
      MODE_BUS_WRITE: begin
        if (!clock_flags[CLK_RESET_BIT]) begin
          unique case (offset)
            OFF_CTRL: begin
              control_word_next = write_data[CtrlW-1:0];
              if (!drain_waiting && tx_fill != '0 && active && write_data[CTRL_TX_EN])
                drain_waiting_next = 1'b1;
            end
            OFF_INT:  interrupt_control_next = write_data[IntW-1:0] & INT_CTRL_MASK;
            OFF_BCLK: bit_clock_word_next = write_data[BclkW-1:0] & BCLK_MASK;
            OFF_FIFO_CFG0: begin
              if (write_data[WR_TX_FLUSH]) begin
                tx_fill_next = '0;
                sticky[1:0]  = 2'b00;
              end
              if (write_data[WR_RX_CLEAR])
                sticky[3:2] = 2'b00;
              fifo_control_flags_next = {write_data[31:8], sticky, 2'b00,
                                         write_data[1:0]};
            end
            OFF_FIFO_CFG1: fifo_thresholds_next = write_data[ThrW-1:0] & THR_MASK;
            OFF_TX_DATA: begin
              if (tx_fill >= Depth) begin
                fifo_control_flags_next[FCF_TX_OVER] = 1'b1;
              end else begin
                tx_fill_next = tx_fill + FillW'(1);
                if (!drain_waiting && active && control_word[CTRL_TX_EN])
                  drain_waiting_next = 1'b1;
              end
            end
            OFF_PIN: pin_config_next = write_data[PinW-1:0];
            default: ;
          endcase
        end
      end
      MODE_DMA_POP: fifo_control_flags_next[FCF_RX_UNDER] = 1'b1;
      MODE_DMA_PUSH: begin
        if (tx_fill >= Depth) begin
          fifo_control_flags_next[FCF_TX_OVER] = 1'b1;
        end else begin
          tx_fill_next = tx_fill + FillW'(1);
          if (!drain_waiting && active && control_word[CTRL_TX_EN])
            drain_waiting_next = 1'b1;
        end
      end
      MODE_DRAIN_TICK: begin
        if (drain_waiting) begin
          drain_waiting_next = 1'b0;
          if (active && control_word[CTRL_TX_EN])
            tx_fill_next = '0;
        end
      end
      MODE_CLOCK_CTRL: begin
        clock_flags_next = {reset_on, module_clock_on, clock_on};
        if (reset_on) begin
          control_word_next       = '0;
          interrupt_control_next  = INT_CTRL_RESET;
          bit_clock_word_next     = BCLK_RESET;
          fifo_control_flags_next = '0;
          fifo_thresholds_next    = '0;
          pin_config_next         = '0;
          tx_fill_next            = '0;
          drain_waiting_next      = 1'b0;
        end else if ({reset_on, module_clock_on, clock_on} != CLK_FLAGS_ACTIVE) begin
          drain_waiting_next = 1'b0;
        end else if (tx_fill != '0 && control_word[CTRL_TX_EN]) begin
          drain_waiting_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // result from the updated state
  assign active_next    = (clock_flags_next == CLK_FLAGS_ACTIVE);
  assign free_next      = Depth - tx_fill_next;
  assign cause_tx_next  = CmpW'(free_next) >
                          CmpW'(fifo_thresholds_next[THR_TX_LO +: 4]);
  assign cause_err_next = |fifo_control_flags_next[7:4];
  assign irq_next = active_next &&
      ((cause_tx_next && interrupt_control_next[INT_TX_EN]
        && !interrupt_control_next[INT_TX_MASK]) ||
       (cause_err_next && interrupt_control_next[INT_ERR_EN]
        && !interrupt_control_next[INT_ERR_MASK]));
  assign wr_ready_next = (dma_width <= DMA_MAX_WIDTH) && active_next &&
                         control_word_next[CTRL_TX_EN] &&
                         fifo_control_flags_next[FCF_DMA_TX_EN] && cause_tx_next;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      control_word       <= '0;
      interrupt_control  <= INT_CTRL_RESET;
      bit_clock_word     <= BCLK_RESET;
      fifo_control_flags <= '0;
      fifo_thresholds    <= '0;
      pin_config         <= '0;
      tx_fill            <= '0;
      drain_waiting      <= 1'b0;
      clock_flags        <= CLK_FLAGS_RESET;
    end else if (accept) begin
      control_word       <= control_word_next;
      interrupt_control  <= interrupt_control_next;
      bit_clock_word     <= bit_clock_word_next;
      fifo_control_flags <= fifo_control_flags_next;
      fifo_thresholds    <= fifo_thresholds_next;
      pin_config         <= pin_config_next;
      tx_fill            <= tx_fill_next;
      drain_waiting      <= drain_waiting_next;
      clock_flags        <= clock_flags_next;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      read_data       <= rd_next;
      irq             <= irq_next;
      dma_write_ready <= wr_ready_next;
      drain_pending   <= drain_waiting_next;
    end
  end

  // no receive path
  assign dma_read_ready = 1'b0;

  // checks
  `IFRB_ASSERT_ALWAYS(a_fill_bound, tx_fill <= Depth, "tx fill count above depth")
  `IFRB_ASSERT_ALWAYS(a_no_drain_in_reset, !(clock_flags[CLK_RESET_BIT] && drain_waiting), "drain pending while reset asserted")
  `IFRB_ASSERT_NEXT(a_accept_gives_result, accept, out_valid, "accepted beat gave no result")

endmodule

// ----- tb/i2s_fifo_register_block_checker.sv -----
module i2s_fifo_register_block_checker
  import i2sfrb_pkg::*;
#(
  parameter int FIFO_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  mode,
  input  logic [7:0]  offset,
  input  logic [31:0] write_data,
  input  logic [3:0]  dma_width,
  input  logic        clock_on,
  input  logic        module_clock_on,
  input  logic        reset_on,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] read_data,
  input  logic        irq,
  input  logic        dma_write_ready,
  input  logic        dma_read_ready,
  input  logic        drain_pending,
  output int          mismatches,
  output int          outstanding,
  output int          results_checked,
  output int          overflow_hits
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] STICKY_MASK   = 32'h000000F0;
  localparam logic [31:0] FCF_WR_KEEP   = ~32'h000000FC;
  localparam int          PRINT_CAP     = 60;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq;
    logic        wr_ready;
    logic        rd_ready;
    logic        drain;
  } beat_result_t;

  // shadow copy of the register file
  logic [CtrlW-1:0] ctl_reg;
  logic [IntW-1:0]  int_reg;
  logic [BclkW-1:0] bclk_reg;
  logic [31:0]      fifo_flags;
  logic [ThrW-1:0]  thresh_reg;
  logic [PinW-1:0]  pin_reg;
  int               tx_level;
  logic             drain_armed;
  logic [2:0]       clk_flags;

  beat_result_t expected_q[$];

  function automatic logic is_running();
    return clk_flags == CLK_FLAGS_ACTIVE;
  endfunction

  function automatic int tx_room();
    return FIFO_DEPTH - tx_level;
  endfunction

  function automatic logic room_hit();
    return tx_room() > int'(thresh_reg[THR_TX_LO +: 4]);
  endfunction

  function automatic logic err_hit();
    return |(fifo_flags & STICKY_MASK);
  endfunction

  function automatic void arm_drain();
    if (!drain_armed && tx_level != 0 && is_running() && ctl_reg[CTRL_TX_EN])
      drain_armed = 1'b1;
  endfunction

  // one word into the transmit fifo, overflow when full
  function automatic void take_word();
    if (tx_level >= FIFO_DEPTH) begin
      fifo_flags[FCF_TX_OVER] = 1'b1;
      overflow_hits++;
    end else begin
      tx_level++;
      arm_drain();
    end
  endfunction

  function automatic void clear_regs();
    ctl_reg     = '0;
    int_reg     = INT_CTRL_RESET;
    bclk_reg    = BCLK_RESET;
    fifo_flags  = '0;
    thresh_reg  = '0;
    pin_reg     = '0;
    tx_level    = 0;
    drain_armed = 1'b0;
  endfunction

  function automatic logic [31:0] reg_read(logic [7:0] off);
    case (off)
      OFF_CTRL:      return 32'(ctl_reg);
      OFF_INT:       return 32'(int_reg & INT_CTRL_MASK) | {29'd0, err_hit(), 1'b0, room_hit()};
      OFF_BCLK:      return 32'(bclk_reg);
      OFF_FIFO_CFG0: return fifo_flags;
      OFF_FIFO_CFG1: return 32'(tx_room()) & FREE_MASK;
      OFF_RX_DATA: begin
        fifo_flags[FCF_RX_UNDER] = 1'b1;
        return '0;
      end
      OFF_PIN:       return 32'(pin_reg);
      default:       return '0;
    endcase
  endfunction

  function automatic void reg_write(logic [7:0] off, logic [31:0] wd);
    if (clk_flags[CLK_RESET_BIT])
      return;
    case (off)
      OFF_CTRL: begin
        ctl_reg = wd[CtrlW-1:0];
        arm_drain();
      end
      OFF_INT:  int_reg = wd[IntW-1:0] & INT_CTRL_MASK;
      OFF_BCLK: bclk_reg = wd[BclkW-1:0] & BCLK_MASK;
      OFF_FIFO_CFG0: begin
        if (wd[WR_TX_FLUSH]) begin
          tx_level = 0;
          fifo_flags[5:4] = 2'b00;
        end
        if (wd[WR_RX_CLEAR])
          fifo_flags[7:6] = 2'b00;
        fifo_flags = (fifo_flags & STICKY_MASK) | (wd & FCF_WR_KEEP);
      end
      OFF_FIFO_CFG1: thresh_reg = wd[ThrW-1:0] & THR_MASK;
      OFF_TX_DATA:   take_word();
      OFF_PIN:       pin_reg = wd[PinW-1:0];
      default: ;
    endcase
  endfunction

  // apply one input beat to the shadow state and form its result
  function automatic beat_result_t predict_beat(logic [2:0] m, logic [7:0] off,
                                                logic [31:0] wd, logic [3:0] w,
                                                logic c, logic mc, logic r);
    beat_result_t res;
    res = '0;
    case (m)
      MODE_BUS_READ:  res.read_data = reg_read(off);
      MODE_BUS_WRITE: reg_write(off, wd);
      MODE_DMA_POP:   fifo_flags[FCF_RX_UNDER] = 1'b1;
      MODE_DMA_PUSH:  take_word();
      MODE_DRAIN_TICK: begin
        if (drain_armed) begin
          drain_armed = 1'b0;
          if (is_running() && ctl_reg[CTRL_TX_EN])
            tx_level = 0;
        end
      end
      MODE_CLOCK_CTRL: begin
        clk_flags = {r, mc, c};
        if (clk_flags[CLK_RESET_BIT])
          clear_regs();
        if (!is_running())
          drain_armed = 1'b0;
        else
          arm_drain();
      end
      default: ;
    endcase
    res.irq = is_running() &&
              ((room_hit() && int_reg[INT_TX_EN] && !int_reg[INT_TX_MASK]) ||
               (err_hit() && int_reg[INT_ERR_EN] && !int_reg[INT_ERR_MASK]));
    res.wr_ready = (w <= DMA_MAX_WIDTH) && is_running() && ctl_reg[CTRL_TX_EN] &&
                   fifo_flags[FCF_DMA_TX_EN] && room_hit();
    res.rd_ready = 1'b0;
    res.drain = drain_armed;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP)
      $display("%0t ns: mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // watch both channels: compare output beats, then predict accepted input beats
  always @(posedge clk) begin : watch_proc
    beat_result_t want;
    if (rst) begin
      clear_regs();
      clk_flags = CLK_FLAGS_RESET;
      expected_q.delete();
      outstanding <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_checked++;
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing expected, read_data %08h",
                                    read_data));
        end else begin
          want = expected_q.pop_front();
          if (read_data !== want.read_data)
            report_mismatch($sformatf("read_data %08h, expected %08h",
                                      read_data, want.read_data));
          if (irq !== want.irq)
            report_mismatch($sformatf("irq %b, expected %b", irq, want.irq));
          if (dma_write_ready !== want.wr_ready)
            report_mismatch($sformatf("dma_write_ready %b, expected %b",
                                      dma_write_ready, want.wr_ready));
          if (dma_read_ready !== want.rd_ready)
            report_mismatch($sformatf("dma_read_ready %b, expected %b",
                                      dma_read_ready, want.rd_ready));
          if (drain_pending !== want.drain)
            report_mismatch($sformatf("drain_pending %b, expected %b",
                                      drain_pending, want.drain));
        end
      end
      if (in_valid && !in_stall)
        expected_q.push_back(predict_beat(mode, offset, write_data, dma_width,
                                          clock_on, module_clock_on, reset_on));
      outstanding <= expected_q.size();
    end
  end

endmodule

// ----- tb/i2s_fifo_register_block_tb.sv -----
module i2s_fifo_register_block_tb;
  import i2sfrb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          FIFO_DEPTH  = 16;
  localparam int          CLK_PERIOD  = 10;
  localparam int          BEAT_TARGET = 1550;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          HOLD_CYCLES = 60;
  localparam int          PAUSE_EVERY = 500;
  localparam logic [2:0]  MODE_SPARE6 = 3'd6;
  localparam logic [2:0]  MODE_SPARE7 = 3'd7;
  localparam logic [7:0]  OFF_UNUSED  = 8'h44;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  mode = MODE_BUS_READ;
  logic [7:0]  offset = '0;
  logic [31:0] write_data = '0;
  logic [3:0]  dma_width = '0;
  logic        clock_on = 1'b0;
  logic        module_clock_on = 1'b0;
  logic        reset_on = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] read_data;
  logic        irq;
  logic        dma_write_ready;
  logic        dma_read_ready;
  logic        drain_pending;

  int mismatches;
  int outstanding;
  int results_checked;
  int overflow_hits;

  int beats_sent = 0;
  int directed_beats = 0;
  int cycle_count = 0;
  int mode_hits [8];
  bit no_idle = 1'b0;

  i2s_fifo_register_block #(.FIFO_DEPTH(FIFO_DEPTH)) dut (.*);

  i2s_fifo_register_block_checker #(.FIFO_DEPTH(FIFO_DEPTH)) chk (.*);

  always #(CLK_PERIOD / 2) clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, outstanding);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_idle)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 65)
      return 0;
    if (r < 93)
      return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_offset();
    case ($urandom_range(0, 9))
      0: return OFF_CTRL;
      1: return OFF_INT;
      2: return OFF_BCLK;
      3: return OFF_FIFO_CFG0;
      4: return OFF_FIFO_CFG1;
      5: return OFF_TX_DATA;
      6: return OFF_RX_DATA;
      7: return OFF_PIN;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // present one beat, wait for it to be taken, then maybe idle
  task automatic drive_beat(input logic [2:0] m, input logic [7:0] off,
                            input logic [31:0] wd, input logic [3:0] w,
                            input logic c, input logic mc, input logic r);
    int gap;
    mode            <= m;
    offset          <= off;
    write_data      <= wd;
    dma_width       <= w;
    clock_on        <= c;
    module_clock_on <= mc;
    reset_on        <= r;
    in_valid        <= 1'b1;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    beats_sent++;
    mode_hits[m]++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic simple_beat(input logic [2:0] m);
    drive_beat(m, 8'($urandom_range(0, 255)), $urandom, 4'($urandom_range(0, 8)),
               1'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic bus_rd(input logic [7:0] off);
    drive_beat(MODE_BUS_READ, off, $urandom, 4'($urandom_range(0, 8)),
               1'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic bus_wr(input logic [7:0] off, input logic [31:0] wd);
    drive_beat(MODE_BUS_WRITE, off, wd, 4'($urandom_range(0, 8)),
               1'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic dma_push(input logic [3:0] w, input logic [31:0] wd);
    drive_beat(MODE_DMA_PUSH, 8'($urandom_range(0, 255)), wd, w,
               1'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic clk_ctl(input logic c, input logic mc, input logic r);
    drive_beat(MODE_CLOCK_CTRL, 8'($urandom_range(0, 255)), $urandom,
               4'($urandom_range(0, 8)), c, mc, r);
  endtask

  // stop offering and wait until every result is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0)
      @(posedge clk);
  endtask

  // fill the tx fifo with a burst, then usually drain it
  task automatic fill_and_drain();
    int n;
    if ($urandom_range(0, 2) == 0)
      bus_wr(OFF_CTRL, ($urandom_range(0, 9) == 0) ? $urandom : ($urandom | 32'h4));
    if ($urandom_range(0, 2) == 0)
      bus_wr(OFF_FIFO_CFG0, ($urandom_range(0, 4) == 0) ? $urandom : ($urandom | 32'h1));
    if ($urandom_range(0, 3) == 0)
      bus_wr(OFF_FIFO_CFG1, $urandom);
    n = $urandom_range(1, 20);
    repeat (n) begin
      if ($urandom_range(0, 9) < 7)
        dma_push(4'($urandom_range(0, 8)), rand_word());
      else
        bus_wr(OFF_TX_DATA, rand_word());
      case ($urandom_range(0, 19))
        0, 1:    bus_rd(OFF_INT);
        2:       bus_rd(OFF_FIFO_CFG1);
        3:       simple_beat(MODE_DRAIN_TICK);
        default: ;
      endcase
    end
    if ($urandom_range(0, 9) < 7)
      simple_beat(MODE_DRAIN_TICK);
    bus_rd(OFF_FIFO_CFG1);
  endtask

  // register write and read back
  task automatic reg_roundtrip();
    logic [7:0] off;
    off = pick_offset();
    bus_wr(off, rand_word());
    bus_rd(off);
  endtask

  // underflow and sticky flag handling
  task automatic error_flags();
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(0, 1))
        simple_beat(MODE_DMA_POP);
      else
        bus_rd(OFF_RX_DATA);
    end
    bus_rd(OFF_FIFO_CFG0);
    if ($urandom_range(0, 1))
      bus_wr(OFF_INT, rand_word());
    bus_rd(OFF_INT);
    if ($urandom_range(0, 1))
      bus_wr(OFF_FIFO_CFG0, $urandom);
  endtask

  // clock or reset change, some traffic, then usually back to running
  task automatic clock_event();
    clk_ctl(1'($urandom), 1'($urandom), ($urandom_range(0, 3) == 0));
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 4))
        0:       bus_rd(pick_offset());
        1:       bus_wr(pick_offset(), rand_word());
        2:       dma_push(4'($urandom_range(0, 8)), $urandom);
        3:       simple_beat(MODE_DRAIN_TICK);
        default: simple_beat(MODE_DMA_POP);
      endcase
    end
    if ($urandom_range(0, 9) < 8)
      clk_ctl(1'b1, 1'b1, 1'b0);
  endtask

  // receiver: random stalls, a long hold-off twice
  initial begin : receiver
    int stall_pct;
    int hold_count;
    int phase_cycles;
    stall_pct = 0;
    hold_count = 0;
    phase_cycles = 0;
    @(posedge clk);
    while (rst)
      @(posedge clk);
    forever begin
      if ((hold_count == 0 && beats_sent >= 400) || (hold_count == 1 && beats_sent >= 1100)) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_count++;
      end else if ($urandom_range(0, 99) < 2) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(10, 25)) @(posedge clk);
      end else begin
        if (phase_cycles == 0) begin
          case ($urandom_range(0, 3))
            0:       stall_pct = 0;
            1:       stall_pct = 10;
            2:       stall_pct = 40;
            default: stall_pct = 70;
          endcase
          phase_cycles = 100;
        end
        phase_cycles--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
        @(posedge clk);
      end
    end
  end

  // sender: reset, directed beats, random sequences, verdict
  initial begin : sender
    int next_pause;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset values, unknown offset, extremes of every register
    bus_rd(OFF_INT);
    bus_rd(OFF_BCLK);
    bus_rd(OFF_UNUSED);
    bus_wr(OFF_CTRL, '1);
    bus_wr(OFF_FIFO_CFG0, '1);
    bus_wr(OFF_FIFO_CFG1, '1);
    dma_push(4'd0, '0);
    dma_push(4'd8, '1);
    bus_rd(OFF_FIFO_CFG1);
    // drain with one pending, then with none
    simple_beat(MODE_DRAIN_TICK);
    simple_beat(MODE_DRAIN_TICK);
    bus_wr(OFF_TX_DATA, '1);
    // empty receive side
    simple_beat(MODE_DMA_POP);
    bus_rd(OFF_RX_DATA);
    bus_rd(OFF_FIFO_CFG0);
    bus_wr(OFF_INT, '1);
    bus_wr(OFF_BCLK, '1);
    bus_wr(OFF_PIN, '1);
    bus_rd(OFF_PIN);
    // reset asserted: writes dropped, pushes still counted
    clk_ctl(1'b1, 1'b1, 1'b1);
    bus_wr(OFF_CTRL, '1);
    dma_push(4'd4, $urandom);
    clk_ctl(1'b0, 1'b0, 1'b0);
    clk_ctl(1'b1, 1'b1, 1'b0);
    simple_beat(MODE_SPARE6);
    simple_beat(MODE_SPARE7);
    bus_wr(OFF_UNUSED, '1);
    directed_beats = beats_sent;
    wait_drained();

    // random sequences, mostly well formed
    next_pause = PAUSE_EVERY;
    while (beats_sent < BEAT_TARGET) begin
      no_idle = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 99)) inside
        [0:39]:  fill_and_drain();
        [40:59]: reg_roundtrip();
        [60:74]: error_flags();
        [75:89]: clock_event();
        default: drive_beat(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), $urandom,
                            4'($urandom_range(0, 8)), 1'($urandom), 1'($urandom),
                            1'($urandom));
      endcase
      if (beats_sent >= next_pause) begin
        wait_drained();
        next_pause += PAUSE_EVERY;
      end
    end

    wait_drained();
    repeat (5) @(posedge clk);
    $display("covered %0d beats (%0d directed), %0d results compared, %0d pushes into a full fifo",
             beats_sent, directed_beats, results_checked, overflow_hits);
    $display("reads %0d, writes %0d, pops %0d, pushes %0d, drain ticks %0d, clock events %0d",
             mode_hits[MODE_BUS_READ], mode_hits[MODE_BUS_WRITE], mode_hits[MODE_DMA_POP],
             mode_hits[MODE_DMA_PUSH], mode_hits[MODE_DRAIN_TICK], mode_hits[MODE_CLOCK_CTRL]);
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- i2s_fifo_register_block.f -----
+incdir+hw/rtl
hw/rtl/i2sfrb_pkg.sv
hw/rtl/i2s_fifo_register_block.sv
tb/i2s_fifo_register_block_checker.sv
tb/i2s_fifo_register_block_tb.sv
